FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle, off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle, always on
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Types, constants and helpers of the escape-time pixel pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned PROD_W   = 64;
   localparam int unsigned COORD_W  = 10;
   localparam int unsigned STEP_W   = 31;
   localparam int unsigned MAP_W    = COORD_W + STEP_W;
   localparam int unsigned COLOR_W  = 24;
   localparam int unsigned ITER_W   = 5;
   localparam int unsigned CNT_W    = 8;
   localparam int unsigned ADDR_W   = 4;
   localparam int unsigned DATA_W   = 32;

   localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
   localparam logic [COLOR_W-1:0] COLOR_BLUE  = 24'h0000FF;
   localparam logic [COLOR_W-1:0] COLOR_GREEN = 24'h00FF00;
   localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;
   localparam logic [COLOR_W-1:0] COLOR_RED   = 24'hFF0000;

   localparam logic [CNT_W-1:0] BLACK_BELOW = 8'd5;
   localparam logic [CNT_W-1:0] BLUE_BELOW  = 8'd10;
   localparam logic [CNT_W-1:0] GREEN_BELOW = 8'd15;

   localparam logic [WORD_W-1:0] LEFT_EDGE_RESET = 32'hE000_0000;
   localparam logic [WORD_W-1:0] TOP_EDGE_RESET  = 32'h1000_0000;
   localparam logic [STEP_W-1:0] REAL_STEP_RESET = 31'd786432;
   localparam logic [STEP_W-1:0] IMAG_STEP_RESET = 31'd524288;

   typedef enum logic [1:0] {
      REG_LEFT_EDGE = 2'd0,
      REG_TOP_EDGE  = 2'd1,
      REG_REAL_STEP = 2'd2,
      REG_IMAG_STEP = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] left_edge_real;
      logic signed [WORD_W-1:0] top_edge_imag;
      logic [STEP_W-1:0]        real_step;
      logic [STEP_W-1:0]        imag_step;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0]       column;
      logic [COORD_W-1:0]       row;
      logic signed [WORD_W-1:0] c_re;
      logic signed [WORD_W-1:0] c_im;
      logic signed [WORD_W-1:0] z_re;
      logic signed [WORD_W-1:0] z_im;
      logic [CNT_W-1:0]         count;
      logic                     escaped;
   } pix_type;

   typedef struct packed {
      pix_type                  pix;
      logic signed [PROD_W-1:0] re_sq;
      logic signed [PROD_W-1:0] im_sq;
      logic signed [PROD_W-1:0] re_im;
   } prod_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_column;
      logic [COORD_W-1:0] out_row;
      logic [COLOR_W-1:0] pixel_color;
      logic [ITER_W-1:0]  iterations;
   } rsp_type;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(32'sh7FFF_FFFF);
      lo = -PROD_W'(64'sh8000_0000);
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[WORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/mbe_map.sv
// ----------------------------------------------------------------------------
// mbe_map
// Two-stage mapping of a pixel position to the complex point c.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbe_map (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire mbe_pkg::cfg_type                cfg,
   input  wire logic                            in_valid,
   input  wire logic [mbe_pkg::COORD_W-1:0]     in_column,
   input  wire logic [mbe_pkg::COORD_W-1:0]     in_row,
   output logic                                 out_valid,
   output mbe_pkg::pix_type                     out_pix
);

   logic                           a_valid_ff;
   logic [mbe_pkg::COORD_W-1:0]    a_column_ff;
   logic [mbe_pkg::COORD_W-1:0]    a_row_ff;
   logic [mbe_pkg::MAP_W-1:0]      a_prod_re_ff;
   logic [mbe_pkg::MAP_W-1:0]      a_prod_im_ff;
   logic [mbe_pkg::MAP_W-1:0]      a_prod_re_in;
   logic [mbe_pkg::MAP_W-1:0]      a_prod_im_in;

   logic                           b_valid_ff;
   mbe_pkg::pix_type               b_pix_ff;
   mbe_pkg::pix_type               b_pix_in;

   logic signed [mbe_pkg::PROD_W-1:0] sum_re;
   logic signed [mbe_pkg::PROD_W-1:0] sum_im;

   // stage A: scale position by step
   always_comb begin
      a_prod_re_in = mbe_pkg::MAP_W'(in_column) * mbe_pkg::MAP_W'(cfg.real_step);
      a_prod_im_in = mbe_pkg::MAP_W'(in_row) * mbe_pkg::MAP_W'(cfg.imag_step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_column_ff  <= in_column;
         a_row_ff     <= in_row;
         a_prod_re_ff <= a_prod_re_in;
         a_prod_im_ff <= a_prod_im_in;
      end
   end

   // stage B: offset by window edge and saturate
   always_comb begin
      sum_re = mbe_pkg::PROD_W'(cfg.left_edge_real)
             + $signed(mbe_pkg::PROD_W'(a_prod_re_ff));
      sum_im = mbe_pkg::PROD_W'(cfg.top_edge_imag)
             - $signed(mbe_pkg::PROD_W'(a_prod_im_ff));
      b_pix_in.column  = a_column_ff;
      b_pix_in.row     = a_row_ff;
      b_pix_in.c_re    = mbe_pkg::sat_word(sum_re);
      b_pix_in.c_im    = mbe_pkg::sat_word(sum_im);
      b_pix_in.z_re    = b_pix_in.c_re;
      b_pix_in.z_im    = b_pix_in.c_im;
      b_pix_in.count   = '0;
      b_pix_in.escaped = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_pix_ff <= b_pix_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_pix   = b_pix_ff;

endmodule

`default_nettype wire

FILE: rtl/mbe_iter.sv
// ----------------------------------------------------------------------------
// mbe_iter
// One unrolled z = z*z + c step: products, then escape test and update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbe_iter #(
   parameter int unsigned FRAC_BITS = 28
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire mbe_pkg::pix_type in_pix,
   output logic                  out_valid,
   output mbe_pkg::pix_type      out_pix
);

   localparam logic signed [mbe_pkg::PROD_W-1:0] LIMIT =
      mbe_pkg::PROD_W'(64'sd4) <<< FRAC_BITS;

   logic                 p_valid_ff;
   mbe_pkg::prod_type    p_ff;
   mbe_pkg::prod_type    p_in;

   logic                 u_valid_ff;
   mbe_pkg::pix_type     u_pix_ff;
   mbe_pkg::pix_type     u_pix_in;

   logic signed [mbe_pkg::PROD_W-1:0] re2;
   logic signed [mbe_pkg::PROD_W-1:0] im2;
   logic signed [mbe_pkg::PROD_W-1:0] cross_term;
   logic signed [mbe_pkg::PROD_W-1:0] next_re;
   logic signed [mbe_pkg::PROD_W-1:0] next_im;

   // stage 1: exact products
   always_comb begin
      p_in.pix   = in_pix;
      p_in.re_sq = mbe_pkg::PROD_W'(in_pix.z_re) * mbe_pkg::PROD_W'(in_pix.z_re);
      p_in.im_sq = mbe_pkg::PROD_W'(in_pix.z_im) * mbe_pkg::PROD_W'(in_pix.z_im);
      p_in.re_im = mbe_pkg::PROD_W'(in_pix.z_re) * mbe_pkg::PROD_W'(in_pix.z_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   // stage 2: truncate, test escape, update z
   always_comb begin
      re2        = p_ff.re_sq >>> FRAC_BITS;
      im2        = p_ff.im_sq >>> FRAC_BITS;
      cross_term = p_ff.re_im >>> (FRAC_BITS - 1);
      next_re    = re2 - im2 + mbe_pkg::PROD_W'(p_ff.pix.c_re);
      next_im    = cross_term + mbe_pkg::PROD_W'(p_ff.pix.c_im);
      u_pix_in   = p_ff.pix;
      if (!p_ff.pix.escaped) begin
         if (re2 + im2 >= LIMIT) begin
            u_pix_in.escaped = 1'b1;
         end else begin
            u_pix_in.z_re  = mbe_pkg::sat_word(next_re);
            u_pix_in.z_im  = mbe_pkg::sat_word(next_im);
            u_pix_in.count = p_ff.pix.count + mbe_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_valid_ff <= 1'b0;
      end else if (en) begin
         u_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_pix_ff <= u_pix_in;
      end
   end

   assign out_valid = u_valid_ff;
   assign out_pix   = u_pix_ff;

endmodule

`default_nettype wire

FILE: rtl/mbe_out.sv
// ----------------------------------------------------------------------------
// mbe_out
// Coloring, output register and skid stage of the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbe_out #(
   parameter int unsigned MAX_ITER = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire mbe_pkg::pix_type in_pix,
   output logic                  en,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mbe_pkg::rsp_type      rsp_data
);

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   mbe_pkg::rsp_type     rsp_data_ff;
   mbe_pkg::rsp_type     rsp_data_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   mbe_pkg::rsp_type     skid_data_ff;
   mbe_pkg::rsp_type     skid_data_in;
   mbe_pkg::rsp_type     fresh;
   logic                 take;

   always_comb begin
      fresh.out_column = in_pix.column;
      fresh.out_row    = in_pix.row;
      fresh.iterations = in_pix.count[mbe_pkg::ITER_W-1:0];
      if (in_pix.count >= mbe_pkg::CNT_W'(MAX_ITER)) begin
         fresh.pixel_color = mbe_pkg::COLOR_RED;
      end else if (in_pix.count < mbe_pkg::BLACK_BELOW) begin
         fresh.pixel_color = mbe_pkg::COLOR_BLACK;
      end else if (in_pix.count < mbe_pkg::BLUE_BELOW) begin
         fresh.pixel_color = mbe_pkg::COLOR_BLUE;
      end else if (in_pix.count < mbe_pkg::GREEN_BELOW) begin
         fresh.pixel_color = mbe_pkg::COLOR_GREEN;
      end else begin
         fresh.pixel_color = mbe_pkg::COLOR_WHITE;
      end
   end

   always_comb begin
      take          = rsp_valid_ff && !rsp_stall;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_data_in  = fresh;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in  = fresh;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign en        = !skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time coloring of one pixel per item, fully unrolled pipeline.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | column, row
//   rsp     | out       | rsp_valid / rsp_stall  | out_column, out_row, pixel_color,
//           |           |                        | iterations
//   csr     | in        | APB write / read       | four window registers
//
// One item enters per cycle while req_stall is low; the pipeline has two mapping
// stages, two stages per unrolled iteration and one output register.
// Synchronous reset clears all valid bits and loads the default window.
// A stalled result sits in the output register; one more item fills the skid
// stage, after which req_stall rises and the whole pipeline holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time_pixel #(
   parameter int unsigned MAX_ITER  = 20,
   parameter int unsigned FRAC_BITS = 28
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [mbe_pkg::COORD_W-1:0]     req_column,
   input  wire logic [mbe_pkg::COORD_W-1:0]     req_row,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [mbe_pkg::COORD_W-1:0]          rsp_out_column,
   output logic [mbe_pkg::COORD_W-1:0]          rsp_out_row,
   output logic [mbe_pkg::COLOR_W-1:0]          rsp_pixel_color,
   output logic [mbe_pkg::ITER_W-1:0]           rsp_iterations,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [mbe_pkg::ADDR_W-1:0]      csr_paddr,
   input  wire logic [mbe_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [mbe_pkg::DATA_W-1:0]           csr_prdata,
   output logic                                 csr_pready
);

   mbe_pkg::cfg_type      cfg_ff;
   mbe_pkg::cfg_type      cfg_in;
   mbe_pkg::reg_idx_type  reg_idx;
   logic                  csr_write;
   logic                  en;

   logic                  stage_valid [0:MAX_ITER];
   mbe_pkg::pix_type      stage_pix   [0:MAX_ITER];
   mbe_pkg::rsp_type      rsp_data;

   // configuration registers
   always_comb begin
      reg_idx   = mbe_pkg::reg_idx_type'(csr_paddr[mbe_pkg::ADDR_W-1:2]);
      csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
      cfg_in    = cfg_ff;
      if (csr_write) begin
         unique case (reg_idx)
            mbe_pkg::REG_LEFT_EDGE: cfg_in.left_edge_real = csr_pwdata;
            mbe_pkg::REG_TOP_EDGE:  cfg_in.top_edge_imag  = csr_pwdata;
            mbe_pkg::REG_REAL_STEP: cfg_in.real_step = csr_pwdata[mbe_pkg::STEP_W-1:0];
            mbe_pkg::REG_IMAG_STEP: cfg_in.imag_step = csr_pwdata[mbe_pkg::STEP_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_edge_real <= mbe_pkg::LEFT_EDGE_RESET;
         cfg_ff.top_edge_imag  <= mbe_pkg::TOP_EDGE_RESET;
         cfg_ff.real_step      <= mbe_pkg::REAL_STEP_RESET;
         cfg_ff.imag_step      <= mbe_pkg::IMAG_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         mbe_pkg::REG_LEFT_EDGE: csr_prdata = cfg_ff.left_edge_real;
         mbe_pkg::REG_TOP_EDGE:  csr_prdata = cfg_ff.top_edge_imag;
         mbe_pkg::REG_REAL_STEP: csr_prdata = mbe_pkg::DATA_W'(cfg_ff.real_step);
         mbe_pkg::REG_IMAG_STEP: csr_prdata = mbe_pkg::DATA_W'(cfg_ff.imag_step);
         default:                csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_stall  = !en;

   mbe_map u_map (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_column (req_column),
      .in_row    (req_row),
      .out_valid (stage_valid[0]),
      .out_pix   (stage_pix[0])
   );

   for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
      mbe_iter #(
         .FRAC_BITS (FRAC_BITS)
      ) u_iter (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (stage_valid[k]),
         .in_pix    (stage_pix[k]),
         .out_valid (stage_valid[k+1]),
         .out_pix   (stage_pix[k+1])
      );
   end

   mbe_out #(
      .MAX_ITER (MAX_ITER)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[MAX_ITER]),
      .in_pix    (stage_pix[MAX_ITER]),
      .en        (en),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_column  = rsp_data.out_column;
   assign rsp_out_row     = rsp_data.out_row;
   assign rsp_pixel_color = rsp_data.pixel_color;
   assign rsp_iterations  = rsp_data.iterations;

endmodule

`default_nettype wire

FILE: rtl/mbe_checker.sv
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks of the escape-time pixel block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mbe_checker #(
   parameter int unsigned MAX_ITER = 20
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic [mbe_pkg::COORD_W-1:0]     req_column,
   input wire logic [mbe_pkg::COORD_W-1:0]     req_row,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic [mbe_pkg::COORD_W-1:0]     rsp_out_column,
   input wire logic [mbe_pkg::COORD_W-1:0]     rsp_out_row,
   input wire logic [mbe_pkg::COLOR_W-1:0]     rsp_pixel_color,
   input wire logic [mbe_pkg::ITER_W-1:0]      rsp_iterations,
   input wire logic                            csr_psel,
   input wire logic                            csr_penable,
   input wire logic                            csr_pwrite,
   input wire logic [mbe_pkg::ADDR_W-1:0]      csr_paddr,
   input wire logic [mbe_pkg::DATA_W-1:0]      csr_pwdata,
   input wire logic [mbe_pkg::DATA_W-1:0]      csr_prdata,
   input wire logic                            csr_pready
);

   logic unused_ok;
   assign unused_ok = ^{req_valid, req_column, req_row, rsp_out_column, rsp_out_row,
                        csr_psel, csr_penable, csr_pwrite, csr_paddr, csr_pwdata,
                        csr_prdata};

   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall && !unused_ok || !rsp_valid && !req_stall)

   `ASSERT_SAME(a_pready_high, clock, reset, 1'b1, csr_pready)

   `ASSERT_SAME(a_red_full_count, clock, reset, rsp_valid && rsp_pixel_color == mbe_pkg::COLOR_RED, rsp_iterations == mbe_pkg::ITER_W'(MAX_ITER))

   `ASSERT_SAME(a_black_low_count, clock, reset, rsp_valid && rsp_pixel_color == mbe_pkg::COLOR_BLACK, rsp_iterations < mbe_pkg::ITER_W'(5))

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_color) && $stable(rsp_iterations))

endmodule

bind mandelbrot_escape_time_pixel mbe_checker #(
   .MAX_ITER (MAX_ITER)
) u_checker (.*);

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the escape-time pixel pipeline against a cycle-free model of the
// escape-time iteration. Pixels are pushed through the req channel under
// random idling on both sides, every result is compared field by field with
// the prediction made when its pixel was accepted, and the window registers
// are reprogrammed over the APB port between bursts, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int unsigned MAX_ITER    = 20;
   localparam int unsigned FRAC_BITS   = 28;
   localparam int unsigned LATENCY     = 2 * MAX_ITER + 3;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned QUIET_LIMIT = 3000;
   localparam int unsigned PRINT_LIMIT = 200;
   localparam longint      WORD_MAX    = 64'sh0000_0000_7FFF_FFFF;
   localparam longint      WORD_MIN    = -64'sh0000_0000_8000_0000;
   localparam longint      ESCAPE_SQ   = longint'(4) << FRAC_BITS;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [mbe_pkg::COORD_W-1:0]  req_column;
   logic [mbe_pkg::COORD_W-1:0]  req_row;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [mbe_pkg::COORD_W-1:0]  rsp_out_column;
   logic [mbe_pkg::COORD_W-1:0]  rsp_out_row;
   logic [mbe_pkg::COLOR_W-1:0]  rsp_pixel_color;
   logic [mbe_pkg::ITER_W-1:0]   rsp_iterations;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [mbe_pkg::ADDR_W-1:0]   csr_paddr;
   logic [mbe_pkg::DATA_W-1:0]   csr_pwdata;
   logic [mbe_pkg::DATA_W-1:0]   csr_prdata;
   logic                         csr_pready;

   mbe_pkg::cfg_type    window;
   mbe_pkg::rsp_type    expected_pixels[$];
   int unsigned         failures = 0;
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_idle_pct = 0;
   logic                hold_req = 1'b0;
   logic                hold_ack = 1'b0;
   int unsigned         hold_left = 0;
   int unsigned         quiet_cycles = 0;

   mandelbrot_escape_time_pixel #(
      .MAX_ITER  (MAX_ITER),
      .FRAC_BITS (FRAC_BITS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_column      (req_column),
      .req_row         (req_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_row     (rsp_out_row),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_iterations  (rsp_iterations),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic longint clamp_word(input longint v);
      if (v > WORD_MAX) begin
         return WORD_MAX;
      end
      if (v < WORD_MIN) begin
         return WORD_MIN;
      end
      return v;
   endfunction

   function automatic mbe_pkg::rsp_type color_pixel(input logic [mbe_pkg::COORD_W-1:0] col,
                                                    input logic [mbe_pkg::COORD_W-1:0] row);
      longint            c_re;
      longint            c_im;
      longint            z_re;
      longint            z_im;
      longint            re_sq;
      longint            im_sq;
      longint            cross_term;
      int unsigned       count;
      bit                escaped;
      mbe_pkg::rsp_type  r;
      c_re = clamp_word(longint'($signed(window.left_edge_real))
                        + longint'(col) * longint'(window.real_step));
      c_im = clamp_word(longint'($signed(window.top_edge_imag))
                        - longint'(row) * longint'(window.imag_step));
      z_re = c_re;
      z_im = c_im;
      count = 0;
      escaped = 1'b0;
      while (count < MAX_ITER && !escaped) begin
         re_sq = (z_re * z_re) >>> FRAC_BITS;
         im_sq = (z_im * z_im) >>> FRAC_BITS;
         if (re_sq + im_sq >= ESCAPE_SQ) begin
            escaped = 1'b1;
         end else begin
            cross_term = (z_re * z_im) >>> (FRAC_BITS - 1);
            z_re = clamp_word(re_sq - im_sq + c_re);
            z_im = clamp_word(cross_term + c_im);
            count++;
         end
      end
      r.out_column = col;
      r.out_row    = row;
      if (count >= MAX_ITER) begin
         r.pixel_color = mbe_pkg::COLOR_RED;
      end else if (count < mbe_pkg::BLACK_BELOW) begin
         r.pixel_color = mbe_pkg::COLOR_BLACK;
      end else if (count < mbe_pkg::BLUE_BELOW) begin
         r.pixel_color = mbe_pkg::COLOR_BLUE;
      end else if (count < mbe_pkg::GREEN_BELOW) begin
         r.pixel_color = mbe_pkg::COLOR_GREEN;
      end else begin
         r.pixel_color = mbe_pkg::COLOR_WHITE;
      end
      r.iterations = mbe_pkg::ITER_W'(count);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      failures++;
      if (failures <= PRINT_LIMIT) begin
         $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
      end
   endtask

   // enter and leave at a falling edge
   task automatic send_pixel(input logic [mbe_pkg::COORD_W-1:0] col,
                             input logic [mbe_pkg::COORD_W-1:0] row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_column <= col;
      req_row    <= row;
      do begin
         @(posedge clock);
      end while (req_stall);
      expected_pixels.push_back(color_pixel(col, row));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input mbe_pkg::reg_idx_type idx,
                            input logic [mbe_pkg::DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      case (idx)
         mbe_pkg::REG_LEFT_EDGE: begin
            window.left_edge_real = value;
         end
         mbe_pkg::REG_TOP_EDGE: begin
            window.top_edge_imag = value;
         end
         mbe_pkg::REG_REAL_STEP: begin
            window.real_step = value[mbe_pkg::STEP_W-1:0];
         end
         default: begin
            window.imag_step = value[mbe_pkg::STEP_W-1:0];
         end
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_window(input logic [mbe_pkg::DATA_W-1:0] left,
                                 input logic [mbe_pkg::DATA_W-1:0] top,
                                 input logic [mbe_pkg::DATA_W-1:0] re_step,
                                 input logic [mbe_pkg::DATA_W-1:0] im_step);
      wait_drained();
      write_csr(mbe_pkg::REG_LEFT_EDGE, left);
      write_csr(mbe_pkg::REG_TOP_EDGE, top);
      write_csr(mbe_pkg::REG_REAL_STEP, re_step);
      write_csr(mbe_pkg::REG_IMAG_STEP, im_step);
   endtask

   task automatic random_window();
      logic [mbe_pkg::DATA_W-1:0] left;
      logic [mbe_pkg::DATA_W-1:0] top;
      logic [mbe_pkg::DATA_W-1:0] re_step;
      logic [mbe_pkg::DATA_W-1:0] im_step;
      if ($urandom_range(3) != 0) begin
         // zoom somewhere around the set, spans up to about three units
         left    = 32'hD800_0000 + $urandom_range(32'h2000_0000);
         top     = $urandom_range(32'h1800_0000);
         re_step = {1'($urandom()), 31'($urandom_range(32'h000C_0000, 32'h40))};
         im_step = {1'($urandom()), 31'($urandom_range(32'h000C_0000, 32'h40))};
      end else begin
         left    = $urandom();
         top     = $urandom();
         re_step = $urandom();
         im_step = $urandom();
      end
      program_window(left, top, re_step, im_step);
   endtask

   task automatic test_default_window();
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd0, 10'd512);
      send_pixel(10'd683, 10'd512);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd342, 10'd512);
      send_pixel(10'd427, 10'd461);
      send_pixel(10'd768, 10'd512);
      send_pixel(10'd770, 10'd512);
      send_pixel(10'd437, 10'd256);
      send_pixel(10'd600, 10'd230);
   endtask

   task automatic test_extreme_windows();
      // saturate both coordinates
      program_window(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd1, 10'd0);
      send_pixel(10'd0, 10'd1);
      // zero steps, the dropped top bit set
      program_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd0);
      // smallest nonzero steps from the origin
      program_window(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd1023, 10'd0);
   endtask

   task automatic test_random_pixels(input int unsigned windows, input int unsigned per_window);
      for (int unsigned w = 0; w < windows; w++) begin
         random_window();
         for (int unsigned i = 0; i < per_window; i++) begin
            send_pixel(mbe_pkg::COORD_W'($urandom_range(1023)),
                       mbe_pkg::COORD_W'($urandom_range(1023)));
         end
      end
   endtask

   task automatic test_backpressure();
      program_window(32'hE000_0000, 32'h1000_0000, 32'h000C_0000, 32'h0008_0000);
      hold_req = ~hold_req;
      for (int unsigned i = 0; i < 90; i++) begin
         send_pixel(mbe_pkg::COORD_W'($urandom_range(1023)),
                    mbe_pkg::COORD_W'($urandom_range(1023)));
      end
      // pause until the pipeline is empty, then a short burst
      wait_drained();
      for (int unsigned i = 0; i < 5; i++) begin
         send_pixel(mbe_pkg::COORD_W'($urandom_range(1023)),
                    mbe_pkg::COORD_W'($urandom_range(1023)));
      end
   endtask

   always @(negedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_result
      mbe_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected result, column", rsp_out_column, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_out_column !== want.out_column) begin
               report_mismatch("out_column", rsp_out_column, want.out_column);
            end
            if (rsp_out_row !== want.out_row) begin
               report_mismatch("out_row", rsp_out_row, want.out_row);
            end
            if (rsp_pixel_color !== want.pixel_color) begin
               report_mismatch("pixel_color", rsp_pixel_color, want.pixel_color);
            end
            if (rsp_iterations !== want.iterations) begin
               report_mismatch("iterations", rsp_iterations, want.iterations);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: %0d cycles without an item", quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_column  = '0;
      req_row     = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      window.left_edge_real = mbe_pkg::LEFT_EDGE_RESET;
      window.top_edge_imag  = mbe_pkg::TOP_EDGE_RESET;
      window.real_step      = mbe_pkg::REAL_STEP_RESET;
      window.imag_step      = mbe_pkg::IMAG_STEP_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 15;
      recv_idle_pct = 70;
      test_default_window();
      test_extreme_windows();
      test_random_pixels(4, 70);

      send_idle_pct = 70;
      recv_idle_pct = 15;
      test_random_pixels(4, 70);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_pixels(4, 70);
      test_backpressure();

      wait_drained();
      repeat (LATENCY) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         report_mismatch("results missing", expected_pixels.size(), 0);
      end
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
